@@ src/mbp_pkg.sv @@
// shared constants and types of the msb-first bit packer
package mbp_pkg;

   // fixed field widths of the channels
   localparam int CODE_W   = 32;
   localparam int LEN_IN_W = 6;
   localparam int BYTE_W   = 8;
   localparam int USED_W   = 3;

   // default longest code, in bits
   localparam int MAX_CODE_LEN_DEF = 32;

   // bit position that takes the first bit of each byte
   localparam int TOP_BIT = 7;

   // entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // request modes
   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_CLOSE  = 1'b1;

   // per-entry control handed from front to back
   typedef struct packed {
      logic              close;
      logic              present;
      logic [USED_W-1:0] used;
   } ctl_type;

endpackage

@@ src/mbp_if.sv @@
// valid/ready channel interfaces for requests and result bytes

interface mbp_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [mbp_pkg::CODE_W-1:0]    code_bits;
   logic [mbp_pkg::LEN_IN_W-1:0]  code_length;

   modport source (output valid, output mode, output code_bits, output code_length,
                   input ready);
   modport sink   (input valid, input mode, input code_bits, input code_length,
                   output ready);
endinterface

interface mbp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mbp_pkg::BYTE_W-1:0]    out_byte;
   logic                          byte_present;
   logic [mbp_pkg::USED_W-1:0]    used_bits;
   logic                          last;

   modport source (output valid, output out_byte, output byte_present, output used_bits,
                   output last, input ready);
   modport sink   (input valid, input out_byte, input byte_present, input used_bits,
                   input last, output ready);
endinterface

@@ src/mbp_front.sv @@
// front end: accepts requests, merges code bits with the pending byte, keeps state
module mbp_front #(
   parameter int MAX_CODE_LEN = mbp_pkg::MAX_CODE_LEN_DEF,
   parameter int ACC_W        = 16,
   parameter int CNT_W        = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic                     in_mode,
   input  logic [mbp_pkg::CODE_W-1:0]   in_code,
   input  logic [mbp_pkg::LEN_IN_W-1:0] in_len,
   output logic                     push_valid,
   input  logic                     push_ready,
   output logic [ACC_W-1:0]         push_stream,
   output logic [CNT_W-1:0]         push_count,
   output mbp_pkg::ctl_type         push_ctl
);
   import mbp_pkg::*;

   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
   localparam int TOT_W = $clog2(MAX_CODE_LEN + 8);
   localparam int SH_W  = $clog2(ACC_W + 1);
   localparam int EXT_W = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

   logic [BYTE_W-1:0] partial_ff, partial_in;
   logic [2:0]        filled_ff, filled_in;

   logic              accept;
   logic [LEN_W-1:0]  len_sat;
   logic [EXT_W-1:0]  code_wide;
   logic [EXT_W-1:0]  code_masked;
   logic [SH_W-1:0]   place_sh;
   logic [ACC_W-1:0]  head_bits;
   logic [ACC_W-1:0]  stream;
   logic [TOT_W-1:0]  total;
   logic [CNT_W-1:0]  nbytes;
   logic [ACC_W-1:0]  rest;

   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;

   // saturate the length and keep only the low code bits
   assign len_sat = (in_len > LEN_IN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                       : LEN_W'(in_len);
   assign code_wide   = EXT_W'(in_code);
   assign code_masked = code_wide & ~({EXT_W{1'b1}} << len_sat);

   // place the code right after the pending bits, left aligned
   assign place_sh  = SH_W'(ACC_W) - SH_W'(filled_ff) - SH_W'(len_sat);
   assign head_bits = {partial_ff, {(ACC_W-BYTE_W){1'b0}}};
   assign stream    = head_bits | (ACC_W'(code_masked[MAX_CODE_LEN-1:0]) << place_sh);

   // full bytes and leftover bits
   assign total  = TOT_W'(filled_ff) + TOT_W'(len_sat);
   assign nbytes = CNT_W'(total >> 3);
   assign rest   = stream << {nbytes, 3'b000};

   // entry for the back end
   always_comb begin
      push_stream      = stream;
      push_count       = nbytes;
      push_ctl.close   = 1'b0;
      push_ctl.present = 1'b1;
      push_ctl.used    = '0;
      push_valid       = in_valid && (nbytes != '0);
      if (in_mode == MODE_CLOSE) begin
         push_stream      = head_bits;
         push_count       = CNT_W'(1);
         push_ctl.close   = 1'b1;
         push_ctl.present = (filled_ff != 3'd0);
         push_ctl.used    = filled_ff;
         push_valid       = in_valid;
      end
   end

   // pending byte update
   always_comb begin
      partial_in = partial_ff;
      filled_in  = filled_ff;
      if (accept) begin
         if (in_mode == MODE_CLOSE) begin
            partial_in = '0;
            filled_in  = '0;
         end else begin
            partial_in = rest[ACC_W-1 -: BYTE_W];
            filled_in  = total[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         filled_ff  <= '0;
      end else begin
         partial_ff <= partial_in;
         filled_ff  <= filled_in;
      end
   end

endmodule

@@ src/mbp_queue.sv @@
// short register queue between front and back
module mbp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = mbp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import mbp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

@@ src/mbp_back.sv @@
// back end: sends each queued entry's bytes via an output register, one per unstalled cycle
module mbp_back #(
   parameter int ACC_W = 16,
   parameter int CNT_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   output logic             head_pop,
   input  logic [ACC_W-1:0] head_stream,
   input  logic [CNT_W-1:0] head_count,
   input  mbp_pkg::ctl_type head_ctl,
   mbp_rsp_if.source        rsp_ch
);
   import mbp_pkg::*;

   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              present_ff, present_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic              last_ff, last_in;

   logic              load;
   logic              final_byte;
   logic [ACC_W-1:0]  shifted;

   assign load       = !valid_ff || rsp_ch.ready;
   assign final_byte = (idx_ff == head_count - 1'b1);
   assign shifted    = head_stream << {idx_ff, 3'b000};
   assign head_pop   = load && head_valid && final_byte;

   // next output transfer
   always_comb begin
      idx_in     = idx_ff;
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      present_in = present_ff;
      used_in    = used_ff;
      last_in    = last_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            byte_in    = shifted[ACC_W-1 -: BYTE_W];
            present_in = head_ctl.present;
            used_in    = head_ctl.close ? head_ctl.used : '0;
            last_in    = final_byte;
            idx_in     = final_byte ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      present_ff <= present_in;
      used_ff    <= used_in;
      last_ff    <= last_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.out_byte     = byte_ff;
   assign rsp_ch.byte_present = present_ff;
   assign rsp_ch.used_bits    = used_ff;
   assign rsp_ch.last         = last_ff;

endmodule

@@ src/msb_first_bit_packer.sv @@
// top level of the msb-first variable-length bit packer
//
//   channel  dir  payload                                      transfer when
//   req_ch   in   mode, code_bits[31:0], code_length[5:0]      valid && ready
//   rsp_ch   out  out_byte[7:0], byte_present, used_bits, last valid && ready
//
// an append yields one result byte per cycle while the receiver is ready, and
// floor((pending + length) / 8) bytes in all, at most 4 at the default length;
// a close yields one result; appends that fill no byte yield no result.
// the front end accepts a request every cycle while the two-entry queue has room,
// and the back end output register gives one byte per cycle while rsp_ch is ready.
// synchronous reset empties the pending byte, the queue and the output register.
// a stalled output holds its byte; the queue lets the front keep accepting meanwhile.
module msb_first_bit_packer #(
   parameter int MAX_CODE_LEN = mbp_pkg::MAX_CODE_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mbp_req_if.sink   req_ch,
   mbp_rsp_if.source rsp_ch
);
   import mbp_pkg::*;

   localparam int ACC_BYTES = (MAX_CODE_LEN + TOP_BIT) / 8 + 1;
   localparam int ACC_W     = 8 * ACC_BYTES;
   localparam int CNT_W     = $clog2(ACC_BYTES);
   localparam int CTL_W     = $bits(ctl_type);
   localparam int ENTRY_W   = ACC_W + CNT_W + CTL_W;

   logic               push_valid, push_ready;
   logic [ACC_W-1:0]   push_stream;
   logic [CNT_W-1:0]   push_count;
   ctl_type            push_ctl;

   logic               head_valid, head_pop;
   logic [ENTRY_W-1:0] head_data;
   logic [ACC_W-1:0]   head_stream;
   logic [CNT_W-1:0]   head_count;
   ctl_type            head_ctl;

   // request intake and state
   mbp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .ACC_W        (ACC_W),
      .CNT_W        (CNT_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .in_mode     (req_ch.mode),
      .in_code     (req_ch.code_bits),
      .in_len      (req_ch.code_length),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_stream (push_stream),
      .push_count  (push_count),
      .push_ctl    (push_ctl)
   );

   // decoupling queue
   mbp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_stream, push_count, push_ctl}),
      .out_valid (head_valid),
      .out_ready (head_pop),
      .out_data  (head_data)
   );

   assign head_stream = head_data[ENTRY_W-1 -: ACC_W];
   assign head_count  = head_data[CTL_W +: CNT_W];
   assign head_ctl    = head_data[CTL_W-1:0];

   // byte emission
   mbp_back #(
      .ACC_W (ACC_W),
      .CNT_W (CNT_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_pop    (head_pop),
      .head_stream (head_stream),
      .head_count  (head_count),
      .head_ctl    (head_ctl),
      .rsp_ch      (rsp_ch)
   );

endmodule

@@ verif/msb_first_bit_packer_tb.sv @@
// self-checking testbench of the msb-first bit packer: random and directed code streams
`timescale 1ns / 100ps

module msb_first_bit_packer_tb;
   import mbp_pkg::*;

   localparam int MAX_LEN      = MAX_CODE_LEN_DEF;
   localparam int LIMIT_CYCLES = 200000;
   localparam int TAIL_CYCLES  = 16;
   localparam int PHASE_ITEMS  = 66;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              present;
      logic [USED_W-1:0] used;
      logic              last;
   } byte_result_type;

   // tracks the packed byte stream the block should emit
   class byte_stream_board;
      byte_result_type expected_bytes[$];
      logic [BYTE_W-1:0] acc_byte;
      int                fill;
      int                errors;

      function new();
         acc_byte = '0;
         fill     = 0;
         errors   = 0;
      endfunction

      task report(string what);
         $display("MISMATCH at %0t ns: %s", $time, what);
         errors++;
      endtask

      function int pending();
         return expected_bytes.size();
      endfunction

      // work out the bytes caused by one accepted request
      function void note_request(logic mode, logic [CODE_W-1:0] code,
                                 logic [LEN_IN_W-1:0] len);
         byte_result_type r;
         int n;
         int nbytes;
         int k;
         if (mode == MODE_CLOSE) begin
            r.out_byte = (fill != 0) ? acc_byte : '0;
            r.present  = (fill != 0);
            r.used     = USED_W'(fill);
            r.last     = 1'b1;
            expected_bytes.push_back(r);
            acc_byte = '0;
            fill     = 0;
            return;
         end
         // overlong codes saturate to the longest code
         n      = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
         nbytes = (fill + n) / BYTE_W;
         k      = 0;
         for (int i = n - 1; i >= 0; i--) begin
            if (i < CODE_W && code[i])
               acc_byte[TOP_BIT - fill] = 1'b1;
            if (fill == TOP_BIT) begin
               k++;
               r.out_byte = acc_byte;
               r.present  = 1'b1;
               r.used     = '0;
               r.last     = (k == nbytes);
               expected_bytes.push_back(r);
               acc_byte = '0;
               fill     = 0;
            end else begin
               fill++;
            end
         end
      endfunction

      // compare one accepted result with the oldest expected byte
      task check_byte(byte_result_type got);
         byte_result_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected result byte %02h", got.out_byte));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
         if (got.present !== want.present)
            report($sformatf("byte_present %b, want %b", got.present, want.present));
         if (got.used !== want.used)
            report($sformatf("used_bits %0d, want %0d", got.used, want.used));
         if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
      endtask
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   stall_pct;
   int   items_sent;
   int   cycle_count;
   byte_result_type got_byte;
   byte_stream_board board = new();

   mbp_req_if req_ch();
   mbp_rsp_if rsp_ch();

   msb_first_bit_packer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // watch both channels for transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_request(req_ch.mode, req_ch.code_bits, req_ch.code_length);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_byte.out_byte = rsp_ch.out_byte;
            got_byte.present  = rsp_ch.byte_present;
            got_byte.used     = rsp_ch.used_bits;
            got_byte.last     = rsp_ch.last;
            board.check_byte(got_byte);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // offer one request and hold it until the transfer
   task automatic send_req(input logic m, input logic [CODE_W-1:0] c,
                           input logic [LEN_IN_W-1:0] l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= m;
      req_ch.code_bits   <= c;
      req_ch.code_length <= l;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // hold off the sender until every expected byte has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      // let the monitor log the last request before looking at the backlog
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
   endtask

   // mostly valid code lengths, with zero, full and overlong ones mixed in
   function automatic logic [LEN_IN_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8)
         return '0;
      if (r < 20)
         return LEN_IN_W'(MAX_LEN);
      if (r < 30)
         return LEN_IN_W'($urandom_range(63, MAX_LEN + 1));
      return LEN_IN_W'($urandom_range(MAX_LEN - 1, 1));
   endfunction

   // random code streams: mostly append runs ended by a close, some noise
   task automatic random_phase(input int n_items);
      int stop_at;
      int runs;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 80) begin
            runs = $urandom_range(6, 1);
            repeat (runs) send_req(MODE_APPEND, $urandom(), pick_length());
            send_req(MODE_CLOSE, $urandom(), LEN_IN_W'($urandom_range(63)));
         end else begin
            send_req(logic'($urandom_range(1)), $urandom(), LEN_IN_W'($urandom_range(63)));
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_APPEND;
      req_ch.code_bits   = '0;
      req_ch.code_length = '0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      items_sent         = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // close on an empty byte
      send_req(MODE_CLOSE, '0, '0);
      // zero-length code
      send_req(MODE_APPEND, 32'hFFFF_FFFF, '0);
      // full-length codes, all ones then all zeros
      send_req(MODE_APPEND, 32'hFFFF_FFFF, 6'd32);
      send_req(MODE_APPEND, 32'h0000_0000, 6'd32);
      // single bit then close
      send_req(MODE_APPEND, 32'h0000_0001, 6'd1);
      send_req(MODE_CLOSE, '0, '0);
      // seven bits pending on close
      send_req(MODE_APPEND, 32'hFFFF_FF7F, 6'd7);
      send_req(MODE_CLOSE, 32'hFFFF_FFFF, 6'd63);
      // overlong lengths saturate
      send_req(MODE_APPEND, 32'hA5A5_A5A5, 6'd63);
      send_req(MODE_APPEND, 32'h8000_0001, 6'd33);
      // codes crossing byte boundaries
      send_req(MODE_APPEND, 32'h0000_0005, 6'd3);
      send_req(MODE_APPEND, 32'hC3C3_5A5A, 6'd32);
      send_req(MODE_APPEND, 32'hFFFF_FF15, 6'd5);
      send_req(MODE_APPEND, 32'h1234_56FF, 6'd8);
      send_req(MODE_APPEND, 32'h0000_0002, 6'd2);
      send_req(MODE_APPEND, 32'h7FFF_FFFF, 6'd31);
      send_req(MODE_CLOSE, 32'h5555_5555, 6'd21);
      send_req(MODE_CLOSE, '0, '0);
      drain();

      // no idling
      random_phase(PHASE_ITEMS);
      drain();
      // sender mostly idle
      send_idle_pct = 73;
      random_phase(PHASE_ITEMS);
      drain();
      // receiver mostly stalled
      send_idle_pct = 0;
      stall_pct     = 73;
      random_phase(PHASE_ITEMS);
      drain();
      // both idle now and then
      send_idle_pct = 21;
      stall_pct     = 21;
      random_phase(PHASE_ITEMS);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
